// ===== src/dhml_pkg.sv =====
package dhml_pkg;

    // Build limits
    localparam int MAX_MIP_LEVELS = 16;
    localparam int MAX_EXTENT     = 65535;
    localparam int RESULT_LIMIT   = 16;
    localparam int LEVEL_LIMIT    = (MAX_MIP_LEVELS < RESULT_LIMIT) ? MAX_MIP_LEVELS
                                                                    : RESULT_LIMIT;
    localparam int LVL_W          = $clog2(RESULT_LIMIT + 1);

    // Header constants
    localparam logic [31:0] DDS_MAGIC_WORD = 32'h2053_4444;
    localparam logic [31:0] DDS_HDR_SIZE   = 32'd124;
    localparam logic [31:0] DDS_PF_SIZE    = 32'd32;
    localparam logic [31:0] FLAGS_REQUIRED = 32'h0000_1007;
    localparam logic [31:0] FLAG_DEPTH     = 32'h0080_0000;
    localparam logic [31:0] FLAG_MIPCOUNT  = 32'h0002_0000;
    localparam logic [31:0] CAPS2_CUBEMAP  = 32'h0000_0200;
    localparam logic [31:0] PF_FOURCC_FLAG = 32'h0000_0004;
    localparam logic [31:0] CC_DXT1        = 32'h3154_5844;
    localparam logic [31:0] CC_DXT2        = 32'h3254_5844;
    localparam logic [31:0] CC_DXT3        = 32'h3354_5844;
    localparam logic [31:0] CC_DXT4        = 32'h3454_5844;
    localparam logic [31:0] CC_DXT5        = 32'h3554_5844;
    localparam logic [31:0] CC_DX10        = 32'h3031_5844;

    // Word positions in the header
    localparam logic [4:0] WPOS_MAGIC  = 5'd0;
    localparam logic [4:0] WPOS_SIZE   = 5'd1;
    localparam logic [4:0] WPOS_FLAGS  = 5'd2;
    localparam logic [4:0] WPOS_HEIGHT = 5'd3;
    localparam logic [4:0] WPOS_WIDTH  = 5'd4;
    localparam logic [4:0] WPOS_DEPTH  = 5'd6;
    localparam logic [4:0] WPOS_MIPS   = 5'd7;
    localparam logic [4:0] WPOS_PFSIZE = 5'd19;
    localparam logic [4:0] WPOS_PFFLAG = 5'd20;
    localparam logic [4:0] WPOS_FOURCC = 5'd21;
    localparam logic [4:0] WPOS_CAPS2  = 5'd28;
    localparam logic [4:0] WPOS_LAST   = 5'd31;

    // Status codes
    localparam logic [3:0] ST_OK        = 4'd0;
    localparam logic [3:0] ST_MAGIC     = 4'd1;
    localparam logic [3:0] ST_SIZE      = 4'd2;
    localparam logic [3:0] ST_FLAGS     = 4'd3;
    localparam logic [3:0] ST_PFSIZE    = 4'd4;
    localparam logic [3:0] ST_DX10      = 4'd5;
    localparam logic [3:0] ST_CUBEMAP   = 4'd6;
    localparam logic [3:0] ST_FORMAT    = 4'd7;
    localparam logic [3:0] ST_ZERO      = 4'd8;
    localparam logic [3:0] ST_TOO_LARGE = 4'd9;

    // Format codes
    localparam logic [1:0] FMT_BC1 = 2'd0;
    localparam logic [1:0] FMT_BC2 = 2'd1;
    localparam logic [1:0] FMT_BC3 = 2'd2;

    // Multiplier operand widths
    localparam int MUL_A_W = 33;
    localparam int MUL_B_W = 16;
    localparam int MUL_P_W = MUL_A_W + MUL_B_W;

    // Header facts, decoded as each word arrives
    typedef struct packed {
        logic             magic_ok;
        logic             hsize_ok;
        logic             req_ok;
        logic             vol;
        logic             mipflag;
        logic             w_zero;
        logic             w_big;
        logic [15:0]      w16;
        logic             h_zero;
        logic             h_big;
        logic [15:0]      h16;
        logic             d_zero;
        logic             d_big;
        logic [15:0]      d16;
        logic             mc_zero;
        logic [LVL_W-1:0] mc_clamp;
        logic             pfsize_ok;
        logic             fourcc_on;
        logic             is_dx10;
        logic             fmt_valid;
        logic [1:0]       fmt;
        logic             cube;
    } hdr_info_t;

    // Sequencer states
    typedef enum logic [2:0] {
        S_LOAD,
        S_EVAL,
        S_ROW,
        S_MUL1,
        S_MUL2,
        S_SIZE,
        S_OUT
    } seq_state_t;

endpackage

// ===== src/dds_header_mip_layout.sv =====
// DDS header parser with BC1..BC3 mip layout. Header words are taken one per
// cycle (32 items, magic first); the 32nd word starts evaluation and the block
// stops taking words until the run is delivered. A check state follows, then
// either a single error item or one item per mip level, each level passing
// through stride setup, two passes through the one shared multiplier for
// slice and level size, one load and an output state that holds for any
// output stall. Words are taken again in the cycle after the final item is
// accepted.
module dds_header_mip_layout (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        header_valid,
    output logic        header_ready,
    input  logic [31:0] header_word,
    output logic        result_valid,
    input  logic        result_ready,
    output logic [3:0]  status,
    output logic [3:0]  mip_index,
    output logic        is_volume,
    output logic [1:0]  format_code,
    output logic [15:0] level_width,
    output logic [15:0] level_height,
    output logic [15:0] level_depth,
    output logic [18:0] row_stride,
    output logic [32:0] slice_stride,
    output logic [48:0] level_offset,
    output logic [47:0] level_size,
    output logic        last
);
    import dhml_pkg::*;

    logic               accept;
    logic               last_word;
    logic               idle;
    hdr_info_t          info;
    logic               mul_en;
    logic [MUL_A_W-1:0] mul_a;
    logic [MUL_B_W-1:0] mul_b;
    logic [MUL_P_W-1:0] mul_p;

    assign header_ready = idle;
    assign accept       = header_valid && idle;

    dhml_capture u_capture (
        .clk         (clk),
        .rst_n       (rst_n),
        .accept      (accept),
        .header_word (header_word),
        .last_word   (last_word),
        .info        (info)
    );

    dhml_mul u_mul (
        .clk     (clk),
        .en      (mul_en),
        .a       (mul_a),
        .b       (mul_b),
        .product (mul_p)
    );

    dhml_seq u_seq (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (accept && last_word),
        .info         (info),
        .idle         (idle),
        .mul_en       (mul_en),
        .mul_a        (mul_a),
        .mul_b        (mul_b),
        .mul_p        (mul_p),
        .res_valid    (result_valid),
        .res_ready    (result_ready),
        .status       (status),
        .mip_index    (mip_index),
        .is_volume    (is_volume),
        .format_code  (format_code),
        .level_width  (level_width),
        .level_height (level_height),
        .level_depth  (level_depth),
        .row_stride   (row_stride),
        .slice_stride (slice_stride),
        .level_offset (level_offset),
        .level_size   (level_size),
        .last         (last)
    );

endmodule

// ===== src/dhml_capture.sv =====
module dhml_capture (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                accept,
    input  logic [31:0]         header_word,
    output logic                last_word,
    output dhml_pkg::hdr_info_t info
);
    import dhml_pkg::*;

    logic [4:0] cnt_reg, cnt_next;
    hdr_info_t  info_reg, info_next;

    // Word position counter
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else
        begin
            cnt_reg <= cnt_next;
        end
    end

    // Decoded header fields
    always_ff @(posedge clk)
    begin
        info_reg <= info_next;
    end

    // Decode each word by position
    always_comb
    begin
        cnt_next  = cnt_reg;
        info_next = info_reg;
        if (accept)
        begin
            cnt_next = cnt_reg + 5'd1;
            case (cnt_reg)
                WPOS_MAGIC:  info_next.magic_ok = (header_word == DDS_MAGIC_WORD);
                WPOS_SIZE:   info_next.hsize_ok = (header_word == DDS_HDR_SIZE);
                WPOS_FLAGS:
                begin
                    info_next.req_ok  = ((header_word & FLAGS_REQUIRED) == FLAGS_REQUIRED);
                    info_next.vol     = ((header_word & FLAG_DEPTH) != '0);
                    info_next.mipflag = ((header_word & FLAG_MIPCOUNT) != '0);
                end
                WPOS_HEIGHT:
                begin
                    info_next.h_zero = (header_word == '0);
                    info_next.h_big  = (header_word > 32'(MAX_EXTENT));
                    info_next.h16    = header_word[15:0];
                end
                WPOS_WIDTH:
                begin
                    info_next.w_zero = (header_word == '0);
                    info_next.w_big  = (header_word > 32'(MAX_EXTENT));
                    info_next.w16    = header_word[15:0];
                end
                WPOS_DEPTH:
                begin
                    info_next.d_zero = (header_word == '0);
                    info_next.d_big  = (header_word > 32'(MAX_EXTENT));
                    info_next.d16    = header_word[15:0];
                end
                WPOS_MIPS:
                begin
                    info_next.mc_zero = (header_word == '0);
                    if (header_word > 32'(LEVEL_LIMIT))
                    begin
                        info_next.mc_clamp = LVL_W'(LEVEL_LIMIT);
                    end
                    else
                    begin
                        info_next.mc_clamp = header_word[LVL_W-1:0];
                    end
                end
                WPOS_PFSIZE: info_next.pfsize_ok = (header_word == DDS_PF_SIZE);
                WPOS_PFFLAG: info_next.fourcc_on = ((header_word & PF_FOURCC_FLAG) != '0);
                WPOS_FOURCC:
                begin
                    info_next.is_dx10   = (header_word == CC_DX10);
                    info_next.fmt_valid = 1'b1;
                    info_next.fmt       = FMT_BC1;
                    if (header_word == CC_DXT1)
                    begin
                        info_next.fmt = FMT_BC1;
                    end
                    else if (header_word == CC_DXT2 || header_word == CC_DXT3)
                    begin
                        info_next.fmt = FMT_BC2;
                    end
                    else if (header_word == CC_DXT4 || header_word == CC_DXT5)
                    begin
                        info_next.fmt = FMT_BC3;
                    end
                    else
                    begin
                        info_next.fmt_valid = 1'b0;
                    end
                end
                WPOS_CAPS2:  info_next.cube = ((header_word & CAPS2_CUBEMAP) != '0);
                default:     ;
            endcase
        end
    end

    assign last_word = (cnt_reg == WPOS_LAST);
    assign info      = info_reg;

endmodule

// ===== src/dhml_mul.sv =====
module dhml_mul (
    input  logic                          clk,
    input  logic                          en,
    input  logic [dhml_pkg::MUL_A_W-1:0]  a,
    input  logic [dhml_pkg::MUL_B_W-1:0]  b,
    output logic [dhml_pkg::MUL_P_W-1:0]  product
);
    import dhml_pkg::*;

    logic [MUL_P_W-1:0] prod_reg, prod_next;

    // Shared multiplier, registered product
    always_comb
    begin
        prod_next = prod_reg;
        if (en)
        begin
            prod_next = MUL_P_W'(a) * MUL_P_W'(b);
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= prod_next;
    end

    assign product = prod_reg;

endmodule

// ===== src/dhml_seq.sv =====
module dhml_seq (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  dhml_pkg::hdr_info_t           info,
    output logic                          idle,
    output logic                          mul_en,
    output logic [dhml_pkg::MUL_A_W-1:0]  mul_a,
    output logic [dhml_pkg::MUL_B_W-1:0]  mul_b,
    input  logic [dhml_pkg::MUL_P_W-1:0]  mul_p,
    output logic                          res_valid,
    input  logic                          res_ready,
    output logic [3:0]                    status,
    output logic [3:0]                    mip_index,
    output logic                          is_volume,
    output logic [1:0]                    format_code,
    output logic [15:0]                   level_width,
    output logic [15:0]                   level_height,
    output logic [15:0]                   level_depth,
    output logic [18:0]                   row_stride,
    output logic [32:0]                   slice_stride,
    output logic [48:0]                   level_offset,
    output logic [47:0]                   level_size,
    output logic                          last
);
    import dhml_pkg::*;

    seq_state_t       state_reg, state_next;
    logic [3:0]       status_reg, status_next;
    logic [3:0]       idx_reg, idx_next;
    logic [LVL_W-1:0] levels_reg, levels_next;
    logic             vol_reg, vol_next;
    logic [1:0]       fmt_reg, fmt_next;
    logic [15:0]      w_reg, w_next;
    logic [15:0]      h_reg, h_next;
    logic [15:0]      d_reg, d_next;
    logic [14:0]      bh_reg, bh_next;
    logic [18:0]      row_reg, row_next;
    logic [32:0]      slice_reg, slice_next;
    logic [47:0]      size_reg, size_next;
    logic [48:0]      offset_reg, offset_next;

    logic [3:0]       err;
    logic [14:0]      bw;
    logic             last_lvl;

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_LOAD;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Level datapath
    always_ff @(posedge clk)
    begin
        status_reg <= status_next;
        idx_reg    <= idx_next;
        levels_reg <= levels_next;
        vol_reg    <= vol_next;
        fmt_reg    <= fmt_next;
        w_reg      <= w_next;
        h_reg      <= h_next;
        d_reg      <= d_next;
        bh_reg     <= bh_next;
        row_reg    <= row_next;
        slice_reg  <= slice_next;
        size_reg   <= size_next;
        offset_reg <= offset_next;
    end

    // Header checks in priority order
    always_comb
    begin
        if (!info.magic_ok)
            err = ST_MAGIC;
        else if (!info.hsize_ok)
            err = ST_SIZE;
        else if (!info.req_ok)
            err = ST_FLAGS;
        else if (!info.pfsize_ok)
            err = ST_PFSIZE;
        else if (info.fourcc_on && info.is_dx10)
            err = ST_DX10;
        else if (info.cube)
            err = ST_CUBEMAP;
        else if (!info.fourcc_on || !info.fmt_valid)
            err = ST_FORMAT;
        else if (info.w_zero || info.h_zero)
            err = ST_ZERO;
        else if (info.w_big || info.h_big || (info.vol && info.d_big))
            err = ST_TOO_LARGE;
        else
            err = ST_OK;
    end

    assign bw       = 15'((17'(w_reg) + 17'd3) >> 2);
    assign last_lvl = (status_reg != ST_OK) || ((LVL_W'(idx_reg) + LVL_W'(1)) == levels_reg);

    // Sequencer
    always_comb
    begin
        state_next  = state_reg;
        status_next = status_reg;
        idx_next    = idx_reg;
        levels_next = levels_reg;
        vol_next    = vol_reg;
        fmt_next    = fmt_reg;
        w_next      = w_reg;
        h_next      = h_reg;
        d_next      = d_reg;
        bh_next     = bh_reg;
        row_next    = row_reg;
        slice_next  = slice_reg;
        size_next   = size_reg;
        offset_next = offset_reg;
        mul_en      = 1'b0;
        mul_a       = MUL_A_W'(row_reg);
        mul_b       = MUL_B_W'(bh_reg);

        case (state_reg)
            S_LOAD:
            begin
                if (start)
                begin
                    state_next = S_EVAL;
                end
            end
            S_EVAL:
            begin
                status_next = err;
                idx_next    = '0;
                offset_next = '0;
                if (err != ST_OK)
                begin
                    // error item: every other field zero, last set
                    levels_next = LVL_W'(1);
                    vol_next    = 1'b0;
                    fmt_next    = FMT_BC1;
                    w_next      = '0;
                    h_next      = '0;
                    d_next      = '0;
                    row_next    = '0;
                    slice_next  = '0;
                    size_next   = '0;
                    state_next  = S_OUT;
                end
                else
                begin
                    vol_next = info.vol;
                    fmt_next = info.fmt;
                    w_next   = info.w16;
                    h_next   = info.h16;
                    if (info.vol && !info.d_zero)
                        d_next = info.d16;
                    else
                        d_next = 16'd1;
                    if (info.mipflag && !info.mc_zero)
                        levels_next = info.mc_clamp;
                    else
                        levels_next = LVL_W'(1);
                    state_next = S_ROW;
                end
            end
            S_ROW:
            begin
                bh_next = 15'((17'(h_reg) + 17'd3) >> 2);
                if (fmt_reg == FMT_BC1)
                    row_next = 19'(bw) << 3;
                else
                    row_next = 19'(bw) << 4;
                state_next = S_MUL1;
            end
            S_MUL1:
            begin
                // slice = row stride * block rows
                mul_en     = 1'b1;
                mul_a      = MUL_A_W'(row_reg);
                mul_b      = MUL_B_W'(bh_reg);
                state_next = S_MUL2;
            end
            S_MUL2:
            begin
                // size = slice * depth
                slice_next = mul_p[32:0];
                mul_en     = 1'b1;
                mul_a      = mul_p[MUL_A_W-1:0];
                mul_b      = d_reg;
                state_next = S_SIZE;
            end
            S_SIZE:
            begin
                size_next  = mul_p[47:0];
                state_next = S_OUT;
            end
            S_OUT:
            begin
                if (res_ready)
                begin
                    if (last_lvl)
                    begin
                        state_next = S_LOAD;
                    end
                    else
                    begin
                        idx_next    = idx_reg + 4'd1;
                        offset_next = offset_reg + 49'(size_reg);
                        w_next      = (w_reg > 16'd1) ? (w_reg >> 1) : 16'd1;
                        h_next      = (h_reg > 16'd1) ? (h_reg >> 1) : 16'd1;
                        d_next      = (d_reg > 16'd1) ? (d_reg >> 1) : 16'd1;
                        state_next  = S_ROW;
                    end
                end
            end
            default:
            begin
                state_next = S_LOAD;
            end
        endcase
    end

    assign idle         = (state_reg == S_LOAD);
    assign res_valid    = (state_reg == S_OUT);
    assign status       = status_reg;
    assign mip_index    = idx_reg;
    assign is_volume    = vol_reg;
    assign format_code  = fmt_reg;
    assign level_width  = w_reg;
    assign level_height = h_reg;
    assign level_depth  = d_reg;
    assign row_stride   = row_reg;
    assign slice_stride = slice_reg;
    assign level_offset = offset_reg;
    assign level_size   = size_reg;
    assign last         = last_lvl;

endmodule

// ===== src/dhml_checker.sv =====
module dhml_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        header_ready,
    input logic        result_valid,
    input logic        result_ready,
    input logic [3:0]  status,
    input logic [3:0]  mip_index,
    input logic [15:0] level_width,
    input logic [15:0] level_height,
    input logic [15:0] level_depth,
    input logic [47:0] level_size,
    input logic        last
);
    import dhml_pkg::*;

    // pending item is held until taken
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_ready |=> result_valid)
        else $error("result item dropped before accept");

    // no header words taken while results are pending
    a_excl: assert property (@(posedge clk) disable iff (!rst_n)
        !(header_ready && result_valid))
        else $error("header taken while result pending");

    // error item is alone and blank
    a_err: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && status != ST_OK |->
            last && mip_index == 4'd0 && level_size == '0)
        else $error("malformed error item");

    // good levels never have a zero extent
    a_ext: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && status == ST_OK |->
            level_width != '0 && level_height != '0 && level_depth != '0)
        else $error("zero extent on a good level");

    // after the final item the block takes words again
    a_back: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_ready && last |=> header_ready)
        else $error("not ready after final item");

endmodule

bind dds_header_mip_layout dhml_checker u_dhml_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .header_ready (header_ready),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .status       (status),
    .mip_index    (mip_index),
    .level_width  (level_width),
    .level_height (level_height),
    .level_depth  (level_depth),
    .level_size   (level_size),
    .last         (last)
);
